[sv/int_to_radix_digits_core_macros.svh]
// Assertion macros for the checker file of this block.
`ifndef INT_TO_RADIX_DIGITS_CORE_MACROS_SVH
`define INT_TO_RADIX_DIGITS_CORE_MACROS_SVH

// The antecedent and the consequent hold in the same cycle.
`define ITRD_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/itrd_pkg.sv]
package itrd_pkg;

  localparam int VALUE_W      = 64;
  localparam int DIGIT_W      = 5;
  localparam int BITS_PER_CYC = 8;
  localparam int DIV_CYCLES   = VALUE_W / BITS_PER_CYC;
  localparam int DIV_CNT_W    = $clog2(DIV_CYCLES);

  localparam logic [DIGIT_W-1:0] SIGN_CODE   = 5'd31;
  localparam logic [DIGIT_W-1:0] RADIX_RESET = 5'd30;
  localparam logic [DIGIT_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX   = 5'd30;

  localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] rem;
  } div_res_t;

endpackage

[sv/int_to_radix_digits_core.sv]
// Channel   Ports                                  Handshake
// request   start, busy, in_value                  taken when start and not busy
// result    out_strobe, out_digit, out_last_digit  one cycle per digit, no stall
// config    cfg_we, cfg_wdata                      taken when cfg_we is high
//
// Each digit takes one pass of the single divider, eight quotient bits per cycle.
// A request keeps busy high while it divides and while its digits leave, one per cycle.
// The last digit is on the outputs in the same cycle in which busy falls.
// Reset is synchronous and active low; the digit buffer is not cleared.
// Results cannot be held off, so the block never waits on the receiver.
module int_to_radix_digits_core
  import itrd_pkg::*;
#(
  parameter int MAX_DIGITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  output logic               out_strobe,
  output logic [DIGIT_W-1:0] out_digit,
  output logic               out_last_digit,
  input  logic               cfg_we,
  input  logic [DIGIT_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PRE  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               neg_r, neg_nxt;
  logic [DIGIT_W-1:0] radix_r;
  logic               out_strobe_r, out_strobe_nxt;
  logic [DIGIT_W-1:0] out_digit_r, out_digit_nxt;
  logic               out_last_r, out_last_nxt;
  logic [DIGIT_W-1:0] rd_data_r;
  logic [DIGIT_W-1:0] dig_mem [MAX_DIGITS];

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [DIGIT_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [CNT_W-1:0]   count_m1;

  logic [DIGIT_W-1:0] radix_eff;
  logic [VALUE_W-1:0] mag;
  logic               div_start;
  logic [VALUE_W-1:0] div_dividend;
  logic [VALUE_W-1:0] div_quot;
  div_res_t           div_res;

  itrd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (radix_eff),
    .quotient (div_quot),
    .res      (div_res)
  );

  always_comb begin
    if (radix_r < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix_r > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix_r;
    end
  end

  always_comb begin
    if (!in_value[VALUE_W-1]) begin
      mag = in_value;
    end else if (in_value == VALUE_MIN) begin
      mag = VALUE_MAX;
    end else begin
      mag = ~in_value + VALUE_W'(1);
    end
  end

  assign count_m1 = count_r - CNT_W'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    neg_nxt        = neg_r;
    out_strobe_nxt = 1'b0;
    out_digit_nxt  = out_digit_r;
    out_last_nxt   = 1'b0;
    wr_en          = 1'b0;
    wr_addr        = count_r[IDX_W-1:0];
    wr_data        = div_res.rem;
    rd_addr        = idx_r - IDX_W'(1);
    div_start      = 1'b0;
    div_dividend   = div_quot;
    unique case (state_r)
      ST_IDLE: begin
        div_dividend = mag;
        if (start) begin
          neg_nxt = in_value[VALUE_W-1];
          if (mag == '0) begin
            wr_en     = 1'b1;
            wr_addr   = '0;
            wr_data   = '0;
            count_nxt = CNT_W'(1);
            state_nxt = ST_PRE;
          end else begin
            div_start = 1'b1;
            count_nxt = '0;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (div_quot == '0 || count_r == CNT_W'(MAX_DIGITS - 1)) begin
            state_nxt = ST_PRE;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      ST_PRE: begin
        rd_addr   = count_m1[IDX_W-1:0];
        idx_nxt   = count_m1[IDX_W-1:0];
        state_nxt = ST_EMIT;
        if (neg_r) begin
          out_strobe_nxt = 1'b1;
          out_digit_nxt  = SIGN_CODE;
        end
      end
      ST_EMIT: begin
        out_strobe_nxt = 1'b1;
        out_digit_nxt  = rd_data_r;
        out_last_nxt   = (idx_r == '0);
        if (idx_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r - IDX_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      count_r      <= '0;
      idx_r        <= '0;
      neg_r        <= 1'b0;
      radix_r      <= RADIX_RESET;
      out_strobe_r <= 1'b0;
      out_last_r   <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      idx_r        <= idx_nxt;
      neg_r        <= neg_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_last_r   <= out_last_nxt;
      if (cfg_we) begin
        radix_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_digit_r <= out_digit_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      dig_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= dig_mem[rd_addr];
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_strobe     = out_strobe_r;
  assign out_digit      = out_digit_r;
  assign out_last_digit = out_last_r;

endmodule

[sv/itrd_div.sv]
module itrd_div
  import itrd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VALUE_W-1:0] dividend,
  input  logic [DIGIT_W-1:0] divisor,
  output logic [VALUE_W-1:0] quotient,
  output div_res_t           res
);

  logic [VALUE_W-1:0]   q_r, q_nxt;
  logic [DIGIT_W-1:0]   rem_r, rem_nxt;
  logic [DIGIT_W-1:0]   div_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 running_r;
  logic                 done_r;

  // Restoring division, several quotient bits per cycle.
  always_comb begin
    logic [DIGIT_W:0] t;
    q_nxt   = q_r;
    rem_nxt = rem_r;
    t       = '0;
    for (int k = 0; k < BITS_PER_CYC; k++) begin
      t     = {rem_nxt, q_nxt[VALUE_W-1]};
      q_nxt = {q_nxt[VALUE_W-2:0], 1'b0};
      if (t >= {1'b0, div_r}) begin
        t        = t - {1'b0, div_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = t[DIGIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      cnt_r     <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        running_r <= 1'b1;
        cnt_r     <= '0;
      end else if (running_r) begin
        cnt_r <= cnt_r + DIV_CNT_W'(1);
        if (cnt_r == DIV_CNT_W'(DIV_CYCLES - 1)) begin
          running_r <= 1'b0;
          done_r    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (running_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = q_r;
  assign res.done = done_r;
  assign res.rem  = rem_r;

endmodule

[sv/itrd_checker.sv]
`include "int_to_radix_digits_core_macros.svh"

module itrd_checker
  import itrd_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input logic [DIGIT_W-1:0] out_digit,
  input logic               out_last_digit
);

  logic sign_out;
  logic last_out;
  logic idle_out;

  assign sign_out = out_strobe && (out_digit == SIGN_CODE);
  assign last_out = out_strobe && out_last_digit;
  assign idle_out = out_strobe && !busy;

  `ITRD_ASSERT_NEXT(a_req_sets_busy, clk, rst_n, start && !busy, busy, "busy did not rise")
  `ITRD_ASSERT_SAME(a_sign_not_last, clk, rst_n, sign_out, !out_last_digit, "sign is last")
  `ITRD_ASSERT_NEXT(a_gap_after_last, clk, rst_n, last_out, !out_strobe, "no gap after last")
  `ITRD_ASSERT_SAME(a_idle_only_last, clk, rst_n, idle_out, out_last_digit, "early idle")

endmodule

bind int_to_radix_digits_core itrd_checker u_itrd_checker (.*);
